// ===== hdl/urc_pkg.sv =====
`default_nettype none
package urc_pkg;

  // Field widths
  localparam int unsigned TICK_W = 16;
  localparam int unsigned DIST_W = 11;

  // Trigger pulse length after reset, in ticks
  localparam logic [TICK_W-1:0] TRIG_TICKS_RESET = 16'd160;

  // Width / 58 as (width * 36158) >> 21, exact for any 16-bit width
  localparam logic [TICK_W-1:0] CM_RECIP = 16'd36158;
  localparam int unsigned CM_SHIFT = 21;
  localparam int unsigned PROD_W = 2 * TICK_W;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_PULSE = 2'd1
  } mode_t;

  // Sequencer stage result, handed to the scaling stage
  typedef struct packed {
    logic              done;
    logic              busy;
    logic              ready;
    logic [TICK_W-1:0] width;
  } stage_t;

endpackage
`default_nettype wire

// ===== hdl/urc_ifs.sv =====
`default_nettype none
// Input item channel: one timer tick
interface urc_in_if;
  logic valid;
  logic ready;
  logic start_request;
  logic echo_level;
  logic read_request;

  modport source(output valid, start_request, echo_level, read_request, input ready);
  modport sink(input valid, start_request, echo_level, read_request, output ready);
endinterface

// Result item channel
interface urc_out_if;
  logic                       valid;
  logic                       ready;
  logic                       trigger_out;
  logic [urc_pkg::DIST_W-1:0] distance_cm;
  logic                       distance_ready;
  logic                       busy_res;

  modport source(output valid, trigger_out, distance_cm, distance_ready, busy_res,
                 input ready);
  modport sink(input valid, trigger_out, distance_cm, distance_ready, busy_res,
               output ready);
endinterface

// Configuration write channel: trigger_ticks
interface urc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [urc_pkg::TICK_W-1:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/urc_sequencer.sv =====
`default_nettype none
module urc_sequencer (
  input  wire logic    clk,
  input  wire logic    rst,
  urc_in_if.sink       samples,
  urc_cfg_if.sink      cfg,
  output urc_pkg::stage_t st,
  output logic         st_valid,
  input  wire logic    st_ready
);
  import urc_pkg::*;

  logic [TICK_W-1:0] trig_ticks;
  logic [TICK_W-1:0] tick_count;
  mode_t             mode;
  mode_t             mode_next;
  logic [TICK_W-1:0] trig_start;
  logic [TICK_W-1:0] echo_start;
  logic              awaiting_fall;
  logic              echo_prev;
  logic              ready_flag;
  logic              ready_next;

  logic              accept;
  logic              rise;
  logic              fall;
  logic              pulse_over;
  logic              started;
  logic              busy_next;
  logic [TICK_W-1:0] width;

  // Config is always writable
  assign cfg.ready = 1'b1;

  // Tick items flow unless the stage register is full and blocked
  assign samples.ready = !st_valid || st_ready;
  assign accept        = samples.valid && samples.ready;

  // Echo edges
  assign rise  = samples.echo_level && !echo_prev && !awaiting_fall;
  assign fall  = !samples.echo_level && echo_prev && awaiting_fall;
  assign width = tick_count - echo_start;

  assign pulse_over = (tick_count - trig_start) >= trig_ticks;

  // Sequencer next state; completion forces idle
  always_comb begin
    mode_next = MODE_IDLE;
    if (!fall) begin
      case (mode)
        MODE_PULSE: mode_next = pulse_over ? MODE_IDLE : MODE_PULSE;
        default:    mode_next = samples.start_request ? MODE_PULSE : MODE_IDLE;
      endcase
    end
  end

  // Sequencer outputs
  always_comb begin
    started   = 1'b0;
    busy_next = 1'b0;
    case (mode)
      MODE_PULSE: started = 1'b0;
      default:    started = !fall && samples.start_request;
    endcase
    case (mode_next)
      MODE_PULSE: busy_next = 1'b1;
      default:    busy_next = 1'b0;
    endcase
  end

  // Ready flag: completion overrides a clear
  always_comb begin
    ready_next = ready_flag;
    if (samples.read_request || started) begin
      ready_next = 1'b0;
    end
    if (fall) begin
      ready_next = 1'b1;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      trig_ticks <= TRIG_TICKS_RESET;
    end else if (cfg.valid && cfg.ready) begin
      trig_ticks <= cfg.data;
    end
  end

  // Ranging state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count    <= '0;
      mode          <= MODE_IDLE;
      trig_start    <= '0;
      echo_start    <= '0;
      awaiting_fall <= 1'b0;
      echo_prev     <= 1'b0;
      ready_flag    <= 1'b0;
    end else if (accept) begin
      tick_count <= tick_count + 1'b1;
      mode       <= mode_next;
      echo_prev  <= samples.echo_level;
      ready_flag <= ready_next;
      if (started) begin
        trig_start <= tick_count;
      end
      if (rise) begin
        echo_start    <= tick_count;
        awaiting_fall <= 1'b1;
      end else if (fall) begin
        awaiting_fall <= 1'b0;
      end
    end
  end

  // Stage register toward the scaling stage
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (accept) begin
      st_valid <= 1'b1;
    end else if (st_ready) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st.done  <= fall;
      st.busy  <= busy_next;
      st.ready <= ready_next;
      st.width <= width;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/urc_scale.sv =====
`default_nettype none
module urc_scale (
  input  wire logic       clk,
  input  wire logic       rst,
  input  urc_pkg::stage_t st,
  input  wire logic       st_valid,
  output logic            st_ready,
  urc_out_if.source       results
);
  import urc_pkg::*;

  logic [PROD_W-1:0] prod;
  logic [DIST_W-1:0] quot;
  logic              advance;

  // Centimeters: width / 58 by reciprocal multiply
  assign prod = st.width * CM_RECIP;
  assign quot = prod[CM_SHIFT +: DIST_W];

  assign st_ready = !results.valid || results.ready;
  assign advance  = st_valid && st_ready;

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (advance) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  // Stored distance doubles as the result field
  always_ff @(posedge clk) begin
    if (rst) begin
      results.distance_cm <= '0;
    end else if (advance && st.done) begin
      results.distance_cm <= quot;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      results.trigger_out    <= st.busy;
      results.busy_res       <= st.busy;
      results.distance_ready <= st.ready;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ultrasonic_range_controller.sv =====
`default_nettype none
// Ultrasonic ranging controller, one timer tick per item.
// Each accepted tick is registered in the sequencer stage, then in
// the scaling stage, whose 16x16 reciprocal multiply sets the split.
// Throughput: 1 tick per cycle while the result side keeps up.
// Reset (rst, synchronous): sequencer idle, timers and distance cleared,
// trigger_ticks back to 160.
module ultrasonic_range_controller (
  input  wire logic clk,
  input  wire logic rst,
  urc_in_if.sink    samples,
  urc_out_if.source results,
  urc_cfg_if.sink   cfg
);
  import urc_pkg::*;

  stage_t st;
  logic   st_valid;
  logic   st_ready;

  urc_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .cfg      (cfg),
    .st       (st),
    .st_valid (st_valid),
    .st_ready (st_ready)
  );

  urc_scale u_scale (
    .clk      (clk),
    .rst      (rst),
    .st       (st),
    .st_valid (st_valid),
    .st_ready (st_ready),
    .results  (results)
  );

endmodule
`default_nettype wire

// ===== hdl/urc_checker.sv =====
`default_nettype none
module urc_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       trigger_out,
  input wire logic                       busy_res,
  input wire logic                       distance_ready,
  input wire logic [urc_pkg::DIST_W-1:0] distance_cm
);

  // A stalled result holds its item
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance_cm)
      && $stable(distance_ready) && $stable(trigger_out))
    else $error("result changed while stalled");

  // Trigger level and busy flag come from the same mode
  a_trig_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> trigger_out == busy_res)
    else $error("trigger_out and busy_res disagree");

  // Input backpressure only when a result is waiting and blocked
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("tick input stalled with result side free");

  // No result right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind ultrasonic_range_controller urc_checker u_urc_checker (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (samples.ready),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .trigger_out    (results.trigger_out),
  .busy_res       (results.busy_res),
  .distance_ready (results.distance_ready),
  .distance_cm    (results.distance_cm)
);
`default_nettype wire
